>>> hdl/rme_pkg.sv
// rme_pkg: number format, command codes, lane result type and the rounding
// and saturation helpers of the rotation matrix engine.
// No dependencies; imported by rme_lane, rme_merge and rotation_matrix_engine.
`default_nettype none

package rme_pkg;

	// signed Q2.30 values
	localparam int VALUE_W = 32;
	localparam int FRAC_W  = VALUE_W - 2;
	localparam int PROD_W  = 2 * VALUE_W;
	localparam int RND_W   = PROD_W - FRAC_W;
	localparam int SUM_W   = RND_W + 2;
	localparam int LANES   = 3;
	localparam int TAPS    = 4;

	localparam logic [PROD_W-1:0] RND_HALF  = PROD_W'(1) << (FRAC_W - 1);
	localparam logic [PROD_W-1:0] RND_HALF1 = RND_HALF + PROD_W'(1);
	localparam logic signed [VALUE_W-1:0] Q_ONE = VALUE_W'(1) << FRAC_W;

	// command codes
	localparam logic [2:0] CMD_LOAD = 3'd0;
	localparam logic [2:0] CMD_ROT  = 3'd1;
	localparam logic [2:0] CMD_DROT = 3'd2;
	localparam logic [2:0] CMD_MV   = 3'd3;
	localparam logic [2:0] CMD_MTV  = 3'd4;

	// axis codes; every other code acts as axis 3
	localparam logic [1:0] AXIS_1 = 2'd1;
	localparam logic [1:0] AXIS_2 = 2'd2;

	typedef struct packed {
		logic signed [VALUE_W-1:0] x;
		logic signed [VALUE_W-1:0] y;
		logic                      clip_x;
		logic                      clip_y;
	} lane_res_t;

	// round to FRAC_W fraction bits, ties toward plus infinity; neg rounds -p
	function automatic logic signed [RND_W-1:0] round_prod(
		input logic signed [PROD_W-1:0] p,
		input logic                     neg
	);
		logic [PROD_W-1:0] t;
		t = neg ? (~p + RND_HALF1) : (p + RND_HALF);
		return t[PROD_W-1:FRAC_W];
	endfunction

	function automatic logic signed [SUM_W-1:0] ext_rnd(input logic signed [RND_W-1:0] r);
		return {{(SUM_W - RND_W){r[RND_W-1]}}, r};
	endfunction

	// returns {clip, value}
	function automatic logic [VALUE_W:0] sat_val(input logic signed [SUM_W-1:0] v);
		logic fits;
		fits = (&v[SUM_W-1:VALUE_W-1]) | ~(|v[SUM_W-1:VALUE_W-1]);
		if (fits) begin
			return {1'b0, v[VALUE_W-1:0]};
		end else if (v[SUM_W-1]) begin
			return {1'b1, 1'b1, {(VALUE_W - 1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(VALUE_W - 1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

>>> hdl/rme_lane.sv
// rme_lane: one column/row lane: four registered 32x32 products, then
// rounding, summing and saturation of two result values.
// Depends on rme_pkg.
`default_nettype none

module rme_lane import rme_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic                      mul,
	input  logic signed [VALUE_W-1:0] opa [TAPS],
	input  logic signed [VALUE_W-1:0] opb [TAPS],
	output lane_res_t                 res
);

	logic signed [PROD_W-1:0] prod_s1 [TAPS];
	logic                     mul_s1;
	logic signed [RND_W-1:0]  rnd [TAPS];
	logic signed [SUM_W-1:0]  sum_x, sum_y;
	logic [VALUE_W:0]         sat_x, sat_y;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < TAPS; n++) begin
				prod_s1[n] <= opa[n] * opb[n];
			end
			mul_s1 <= mul;
		end
	end

	// in rotate mode tap 2 is the negated s*m[i] term of the new row j
	always_comb begin
		for (int n = 0; n < TAPS; n++) begin
			rnd[n] = round_prod(prod_s1[n], (n == 2) && !mul_s1);
		end
		sum_x = ext_rnd(rnd[0]) + ext_rnd(rnd[1]) + (mul_s1 ? ext_rnd(rnd[2]) : '0);
		sum_y = ext_rnd(rnd[3]) + (mul_s1 ? '0 : ext_rnd(rnd[2]));
		sat_x = sat_val(sum_x);
		sat_y = sat_val(sum_y);
		res.x      = sat_x[VALUE_W-1:0];
		res.clip_x = sat_x[VALUE_W];
		res.y      = sat_y[VALUE_W-1:0];
		res.clip_y = sat_y[VALUE_W];
	end

endmodule

`default_nettype wire

>>> hdl/rme_merge.sv
// rme_merge: gathers the three lane results of a multiply command into the
// output register and folds the x clip flags of the lanes into one saturation flag.
// Depends on rme_pkg.
`default_nettype none

module rme_merge import rme_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lane_res_t            lane [LANES],
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [LANES*VALUE_W-1:0] m_tdata,   // out_a, out_b, out_c
	output logic [0:0]           m_tuser        // saturated
);

	logic                         valid_q;
	logic [LANES*VALUE_W-1:0]     data_q;
	logic                         sat_q;
	logic                         any_clip;

	assign in_ready = !valid_q || m_tready;

	always_comb begin
		any_clip = 1'b0;
		for (int k = 0; k < LANES; k++) begin
			any_clip = any_clip | lane[k].clip_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int k = 0; k < LANES; k++) begin
				data_q[k*VALUE_W +: VALUE_W] <= lane[k].x;
			end
			sat_q <= any_clip;
		end
	end

	assign m_tvalid   = valid_q;
	assign m_tdata    = data_q;
	assign m_tuser[0] = sat_q;

endmodule

`default_nettype wire

>>> hdl/rotation_matrix_engine.sv
// rotation_matrix_engine: 3x3 Q2.30 matrix with row load, Givens rotations
// and matrix/transpose times vector. Depends on rme_pkg, rme_lane, rme_merge.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-----------------------------------------
//  s (req)   | in  | s_tvalid/s_tready  | tdata sine,cosine,elem_a..c; tuser cmd,axis,row_sel
//  m (resp)  | out | m_tvalid/m_tready  | tdata out_a..c; tuser saturated
//
// One request per cycle; a rotation holds s_tready low for the cycle after its
// acceptance while its rows are written back from the lane sums.
// Multiply responses: product register, then output register.
// Row loads write the matrix at acceptance. Reset loads the identity, empties the pipe.
// With m_tready low the output register and the product stage each hold one
// multiply; after that s_tready falls.
`default_nettype none

module rotation_matrix_engine import rme_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [5*VALUE_W-1:0]          s_tdata,   // sine, cosine, elem_a, elem_b, elem_c
	input  logic [6:0]                    s_tuser,   // cmd[2:0], axis[4:3], row_sel[6:5]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [LANES*VALUE_W-1:0]      m_tdata,   // out_a, out_b, out_c
	output logic [0:0]                    m_tuser    // saturated
);

	// request fields
	logic [2:0]                cmd;
	logic [1:0]                axis;
	logic [1:0]                row_sel;
	logic signed [VALUE_W-1:0] sine, cosine;
	logic signed [VALUE_W-1:0] vec [LANES];

	assign cmd     = s_tuser[2:0];
	assign axis    = s_tuser[4:3];
	assign row_sel = s_tuser[6:5];
	assign sine    = s_tdata[0*VALUE_W +: VALUE_W];
	assign cosine  = s_tdata[1*VALUE_W +: VALUE_W];
	assign vec[0]  = s_tdata[2*VALUE_W +: VALUE_W];
	assign vec[1]  = s_tdata[3*VALUE_W +: VALUE_W];
	assign vec[2]  = s_tdata[4*VALUE_W +: VALUE_W];

	// matrix state, row-major
	logic signed [VALUE_W-1:0] mat_q [LANES][LANES];

	logic s_req, is_mul, is_rot, is_load;
	assign s_req   = s_tvalid && s_tready;
	assign is_mul  = (cmd == CMD_MV) || (cmd == CMD_MTV);
	assign is_rot  = (cmd == CMD_ROT) || (cmd == CMD_DROT);
	assign is_load = (cmd == CMD_LOAD);

	// product stage control
	logic       valid_s1, rot_s1, deriv_s1;
	logic [1:0] row_i_s1, row_j_s1, row_h_s1;
	logic       mrg_ready, s1_adv;

	// rotation rows picked by axis: i and j rotate, h is the axis row
	logic [1:0] row_i, row_j, row_h;
	always_comb begin
		case (axis)
			AXIS_1: begin
				row_h = 2'd0; row_i = 2'd1; row_j = 2'd2;
			end
			AXIS_2: begin
				row_h = 2'd1; row_i = 2'd2; row_j = 2'd0;
			end
			default: begin
				row_h = 2'd2; row_i = 2'd0; row_j = 2'd1;
			end
		endcase
	end

	// lane operands: lane k owns output element k or matrix column k
	logic signed [VALUE_W-1:0] opa [LANES][TAPS];
	logic signed [VALUE_W-1:0] opb [LANES][TAPS];
	logic signed [VALUE_W-1:0] mi [LANES];
	logic signed [VALUE_W-1:0] mj [LANES];

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			case (axis)
				AXIS_1: begin
					mi[k] = mat_q[1][k]; mj[k] = mat_q[2][k];
				end
				AXIS_2: begin
					mi[k] = mat_q[2][k]; mj[k] = mat_q[0][k];
				end
				default: begin
					mi[k] = mat_q[0][k]; mj[k] = mat_q[1][k];
				end
			endcase
			if (is_mul) begin
				for (int n = 0; n < LANES; n++) begin
					opa[k][n] = (cmd == CMD_MV) ? mat_q[k][n] : mat_q[n][k];
					opb[k][n] = vec[n];
				end
				opa[k][3] = '0;
				opb[k][3] = '0;
			end else begin
				opa[k][0] = cosine; opb[k][0] = mi[k];
				opa[k][1] = sine;   opb[k][1] = mj[k];
				opa[k][2] = sine;   opb[k][2] = mi[k];
				opa[k][3] = cosine; opb[k][3] = mj[k];
			end
		end
	end

	// a rotation in the product stage always retires; a multiply needs room
	assign s1_adv   = !valid_s1 || rot_s1 || mrg_ready;
	assign s_tready = s1_adv && !(valid_s1 && rot_s1);

	lane_res_t lane_res [LANES];

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		rme_lane u_lane (
			.clk (clk),
			.en  (s1_adv),
			.mul (is_mul),
			.opa (opa[k]),
			.opb (opb[k]),
			.res (lane_res[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rot_s1   <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= s_req && (is_mul || is_rot);
			rot_s1   <= is_rot;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			deriv_s1 <= (cmd == CMD_DROT);
			row_i_s1 <= row_i;
			row_j_s1 <= row_j;
			row_h_s1 <= row_h;
		end
	end

	// matrix update: loads at acceptance, rotations at the end of the product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < LANES; r++) begin
				for (int k = 0; k < LANES; k++) begin
					mat_q[r][k] <= (r == k) ? Q_ONE : '0;
				end
			end
		end else if (valid_s1 && rot_s1) begin
			for (int r = 0; r < LANES; r++) begin
				for (int k = 0; k < LANES; k++) begin
					if (row_i_s1 == 2'(r)) begin
						mat_q[r][k] <= lane_res[k].x;
					end else if (row_j_s1 == 2'(r)) begin
						mat_q[r][k] <= lane_res[k].y;
					end else if (deriv_s1 && row_h_s1 == 2'(r)) begin
						mat_q[r][k] <= '0;
					end
				end
			end
		end else if (s_req && is_load) begin
			for (int r = 0; r < LANES; r++) begin
				if (row_sel == 2'(r)) begin
					for (int k = 0; k < LANES; k++) begin
						mat_q[r][k] <= vec[k];
					end
				end
			end
		end
	end

	rme_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1 && !rot_s1),
		.in_ready (mrg_ready),
		.lane     (lane_res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// no request may read the matrix while a rotation is being written back
	a_rot_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rot_s1 |-> !s_tready)
		else $error("request accepted during rotation write-back");

	// an accepted rotation occupies the product stage next cycle
	a_rot_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_req && is_rot |=> valid_s1 && rot_s1)
		else $error("rotation lost before write-back");

	// a response only appears after a multiply left the product stage
	a_resp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && !rot_s1))
		else $error("response without a multiply request");

endmodule

`default_nettype wire

>>> bench/tb_rotation_matrix_engine.sv
// tb_rotation_matrix_engine: self-checking bench for the 3x3 rotation matrix engine.
// Depends on rme_pkg and rotation_matrix_engine; a local fixed-point model of the
// matrix predicts every vector result, which is checked field by field.
`default_nettype none

module tb_rotation_matrix_engine;
	import rme_pkg::*;

	localparam int ACC_W      = 2 * VALUE_W + 16;
	localparam int RAND_ITEMS = 1725;

	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (FRAC_W - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) << (VALUE_W - 1)) - 1;
	localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - 1;

	localparam logic [VALUE_W-1:0] Q_MAXV = {1'b0, {(VALUE_W - 1){1'b1}}};
	localparam logic [VALUE_W-1:0] Q_MINV = {1'b1, {(VALUE_W - 1){1'b0}}};
	localparam logic [VALUE_W-1:0] Q_HALF = Q_ONE >>> 1;

	// codes the package does not name
	localparam logic [2:0] CMD_UNUSED_LO = CMD_MTV + 3'd1;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
	localparam logic [1:0] AXIS_ALT      = 2'd0;   // aliases axis 3
	localparam logic [1:0] AXIS_3        = 2'd3;
	localparam logic [1:0] ROW_NONE      = 2'd3;   // load with this row is dropped

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [1:0]         axis;
		logic [1:0]         row;
		logic [VALUE_W-1:0] sn;
		logic [VALUE_W-1:0] cs;
		logic [VALUE_W-1:0] ea;
		logic [VALUE_W-1:0] eb;
		logic [VALUE_W-1:0] ec;
	} rot_req_t;

	typedef struct packed {
		logic                     sat;
		logic [LANES*VALUE_W-1:0] vec;
	} vec_result_t;

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [5*VALUE_W-1:0]     s_tdata  = '0;
	logic [6:0]               s_tuser  = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [LANES*VALUE_W-1:0] m_tdata;
	logic [0:0]               m_tuser;

	rot_req_t    pending_reqs[$];
	vec_result_t expected_vecs[$];
	rot_req_t    on_bus;
	logic [VALUE_W-1:0] mat[9];

	int send_idle_pct = 28;
	int recv_idle_pct = 70;
	int mismatches    = 0;
	int n_req         = 0;
	int n_load        = 0;
	int n_rot         = 0;
	int n_vec         = 0;
	int n_sat         = 0;

	rotation_matrix_engine dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model

	// exact product, optionally negated, rounded half up to FRAC_W fraction bits
	function automatic acc_t rnd_mul(input acc_t a, input acc_t b, input bit neg);
		acc_t p;
		p = a * b;
		if (neg) begin
			p = -p;
		end
		return (p + RND_BIAS) >>> FRAC_W;
	endfunction

	// {clip, value}
	function automatic logic [VALUE_W:0] clamp(input acc_t v);
		if (v > SAT_HI) begin
			return {1'b1, SAT_HI[VALUE_W-1:0]};
		end else if (v < SAT_LO) begin
			return {1'b1, SAT_LO[VALUE_W-1:0]};
		end
		return {1'b0, v[VALUE_W-1:0]};
	endfunction

	task automatic reset_matrix();
		for (int k = 0; k < 9; k++) begin
			mat[k] = (k % 4 == 0) ? Q_ONE : '0;
		end
	endtask

	// Givens rotation of rows i,j; derivative form also clears axis row h
	task automatic rotate_rows(input logic [1:0] ax, input logic [VALUE_W-1:0] s,
			input logic [VALUE_W-1:0] c, input bit deriv);
		int h;
		int i;
		int j;
		logic [VALUE_W:0] na;
		logic [VALUE_W:0] nb;
		h = 2;
		i = 0;
		j = 1;
		if (ax == AXIS_1) begin
			h = 0;
			i = 1;
			j = 2;
		end else if (ax == AXIS_2) begin
			h = 1;
			i = 2;
			j = 0;
		end
		for (int k = 0; k < 3; k++) begin
			na = clamp(rnd_mul($signed(c), $signed(mat[i*3+k]), 1'b0)
				+ rnd_mul($signed(s), $signed(mat[j*3+k]), 1'b0));
			nb = clamp(rnd_mul($signed(s), $signed(mat[i*3+k]), 1'b1)
				+ rnd_mul($signed(c), $signed(mat[j*3+k]), 1'b0));
			mat[i*3+k] = na[VALUE_W-1:0];
			mat[j*3+k] = nb[VALUE_W-1:0];
			if (deriv) begin
				mat[h*3+k] = '0;
			end
		end
	endtask

	// update the matrix for one accepted request; queue a result for multiplies
	task automatic apply_request(input rot_req_t r);
		logic [VALUE_W-1:0] v[3];
		logic [VALUE_W-1:0] m;
		acc_t acc;
		logic [VALUE_W:0] lane;
		vec_result_t res;
		v[0] = r.ea;
		v[1] = r.eb;
		v[2] = r.ec;
		n_req++;
		case (r.op)
			CMD_LOAD: begin
				n_load++;
				if (r.row != ROW_NONE) begin
					for (int k = 0; k < 3; k++) begin
						mat[r.row*3+k] = v[k];
					end
				end
			end
			CMD_ROT, CMD_DROT: begin
				n_rot++;
				rotate_rows(r.axis, r.sn, r.cs, r.op == CMD_DROT);
			end
			CMD_MV, CMD_MTV: begin
				res.sat = 1'b0;
				for (int j = 0; j < 3; j++) begin
					acc = '0;
					for (int i = 0; i < 3; i++) begin
						m = (r.op == CMD_MV) ? mat[j*3+i] : mat[i*3+j];
						acc = acc + rnd_mul($signed(m), $signed(v[i]), 1'b0);
					end
					lane = clamp(acc);
					res.vec[j*VALUE_W +: VALUE_W] = lane[VALUE_W-1:0];
					res.sat |= lane[VALUE_W];
				end
				n_vec++;
				if (res.sat) begin
					n_sat++;
				end
				expected_vecs.push_back(res);
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------ stimulus

	function automatic rot_req_t mk_req(input logic [2:0] op, input logic [1:0] ax,
			input logic [1:0] row, input logic [VALUE_W-1:0] sn,
			input logic [VALUE_W-1:0] cs, input logic [VALUE_W-1:0] ea,
			input logic [VALUE_W-1:0] eb, input logic [VALUE_W-1:0] ec);
		rot_req_t r;
		r.op   = op;
		r.axis = ax;
		r.row  = row;
		r.sn   = sn;
		r.cs   = cs;
		r.ea   = ea;
		r.eb   = eb;
		r.ec   = ec;
		return r;
	endfunction

	// mostly values in +-1.0, some raw patterns and the range ends
	function automatic logic [VALUE_W-1:0] rand_elem();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			case ($urandom_range(4))
				0: return Q_MAXV;
				1: return Q_MINV;
				2: return Q_ONE;
				3: return -Q_ONE;
				default: return '0;
			endcase
		end else if (pick < 4) begin
			return $urandom;
		end
		return $urandom_range(32'h8000_0000, 0) - Q_ONE;
	endfunction

	function automatic rot_req_t rand_req();
		rot_req_t r;
		real th;
		int pick;
		r = mk_req(CMD_LOAD, 2'($urandom_range(3)), 2'($urandom_range(3)), rand_elem(),
			rand_elem(), rand_elem(), rand_elem(), rand_elem());
		pick = $urandom_range(99);
		if (pick < 18) begin
			r.op = CMD_LOAD;
			// mostly real rows, row_sel 3 now and then
			r.row = ($urandom_range(11) == 0) ? ROW_NONE : 2'($urandom_range(2));
		end else if (pick < 44) begin
			r.op = (pick < 36) ? CMD_ROT : CMD_DROT;
			// a true angle most of the time so the matrix stays near unit norm
			if ($urandom_range(3) != 0) begin
				th = $urandom * 6.283185307179586 / 4294967296.0;
				r.sn = $rtoi($sin(th) * 1073741824.0);
				r.cs = $rtoi($cos(th) * 1073741824.0);
			end
		end else if (pick < 70) begin
			r.op = CMD_MV;
		end else if (pick < 96) begin
			r.op = CMD_MTV;
		end else begin
			r.op = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
		end
		return r;
	endfunction

	// ------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			reset_matrix();
		end else begin
			if (s_tvalid && s_tready) begin
				apply_request(on_bus);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {on_bus.ec, on_bus.eb, on_bus.ea, on_bus.cs, on_bus.sn};
					s_tuser  <= {on_bus.row, on_bus.axis, on_bus.op};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------ monitor

	task automatic note_mismatch(input string what, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch on %s: expected %h, got %h", what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vec_result_t want;
		vec_result_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata};
				if (expected_vecs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result %h sat %b", got.vec, got.sat);
					end
				end else begin
					want = expected_vecs.pop_front();
					for (int e = 0; e < LANES; e++) begin
						if (got.vec[e*VALUE_W +: VALUE_W] != want.vec[e*VALUE_W +: VALUE_W]) begin
							note_mismatch($sformatf("element %0d", e),
								want.vec[e*VALUE_W +: VALUE_W], got.vec[e*VALUE_W +: VALUE_W]);
						end
					end
					if (got.sat != want.sat) begin
						note_mismatch("saturated", VALUE_W'(want.sat), VALUE_W'(got.sat));
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ----------------------------------------------------------- sequence

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity passes vectors through, range ends included
		pending_reqs.push_back(mk_req(CMD_MV, AXIS_3, 2'd0, 0, 0, Q_MAXV, Q_MINV, 0));
		pending_reqs.push_back(mk_req(CMD_MTV, AXIS_3, 2'd0, 0, 0, Q_MINV, 1, -1));
		// extreme rows, then multiplies that clip
		pending_reqs.push_back(mk_req(CMD_LOAD, AXIS_3, 2'd0, 0, 0, Q_MAXV, Q_MINV, Q_MAXV));
		pending_reqs.push_back(mk_req(CMD_LOAD, AXIS_3, 2'd1, 0, 0, Q_MINV, Q_MINV, Q_MINV));
		pending_reqs.push_back(mk_req(CMD_LOAD, AXIS_3, 2'd2, 0, 0, Q_MAXV, Q_MAXV, Q_MAXV));
		pending_reqs.push_back(mk_req(CMD_LOAD, AXIS_3, ROW_NONE, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_MV, AXIS_3, 2'd0, 0, 0, Q_MAXV, Q_MAXV, Q_MINV));
		pending_reqs.push_back(mk_req(CMD_MTV, AXIS_3, 2'd0, 0, 0, Q_MINV, Q_MINV, Q_MAXV));
		// unused commands leave the matrix alone
		for (int k = CMD_UNUSED_LO; k <= CMD_UNUSED_HI; k++) begin
			pending_reqs.push_back(mk_req(3'(k), AXIS_1, 2'd0, $urandom, $urandom,
				$urandom, $urandom, $urandom));
		end
		// rotation that overflows the matrix and saturates silently
		pending_reqs.push_back(mk_req(CMD_ROT, AXIS_ALT, 2'd0, Q_MAXV, Q_MINV, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_MV, AXIS_3, 2'd0, 0, 0, Q_ONE, Q_ONE, Q_ONE));
		// half-LSB products: rounding ties, including the negated term
		pending_reqs.push_back(mk_req(CMD_LOAD, AXIS_3, 2'd0, 0, 0, Q_HALF >>> 1, -(Q_HALF >>> 1), 1));
		pending_reqs.push_back(mk_req(CMD_LOAD, AXIS_3, 2'd1, 0, 0, -(Q_HALF >>> 1), Q_HALF >>> 1, -1));
		pending_reqs.push_back(mk_req(CMD_LOAD, AXIS_3, 2'd2, 0, 0, Q_ONE, 0, Q_HALF));
		pending_reqs.push_back(mk_req(CMD_ROT, AXIS_1, 2'd0, 1, Q_ONE, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_ROT, AXIS_2, 2'd0, -1, 1, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_ROT, AXIS_3, 2'd0, 32'sd536870912, 32'sd929887697,
			0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_MV, AXIS_3, 2'd0, 0, 0, Q_ONE, -Q_ONE, Q_HALF));
		// derivative rotations about each axis clear the axis row
		pending_reqs.push_back(mk_req(CMD_DROT, AXIS_1, 2'd0, 32'sd929887697, -32'sd536870912,
			0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_MTV, AXIS_3, 2'd0, 0, 0, Q_HALF, Q_ONE, -Q_HALF));
		pending_reqs.push_back(mk_req(CMD_DROT, AXIS_ALT, 2'd0, Q_HALF, Q_HALF, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_DROT, AXIS_2, 2'd0, Q_ONE, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_MV, AXIS_3, 2'd0, 0, 0, Q_MAXV, Q_ONE, Q_MINV));

		// random traffic in three idling regimes
		for (int ph = 0; ph < 3; ph++) begin
			while (pending_reqs.size() != 0 || s_tvalid) @(posedge clk);
			@(negedge clk);
			send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 70 : 0;
			recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 28 : 0;
			repeat (RAND_ITEMS / 3) pending_reqs.push_back(rand_req());
		end
		while (pending_reqs.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_vecs.size() != 0) @(posedge clk);
		// catch any stray result after the last one expected
		repeat (8) @(posedge clk);

		$display("requests sent: %0d (%0d row loads, %0d rotations, %0d vector multiplies)",
			n_req, n_load, n_rot, n_vec);
		$display("vector results with clipping: %0d; mismatches: %0d", n_sat, mismatches);
		if (mismatches == 0 && expected_vecs.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> rotation_matrix_engine.f
hdl/rme_pkg.sv
hdl/rme_lane.sv
hdl/rme_merge.sv
hdl/rotation_matrix_engine.sv
bench/tb_rotation_matrix_engine.sv
